/* hw/rtl/bit_test_and_scan_unit_macros.svh */
// Assertion macros for the bit test and scan unit.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef BIT_TEST_AND_SCAN_UNIT_MACROS_SVH
`define BIT_TEST_AND_SCAN_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BTSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BTSU_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* hw/rtl/btsu_pkg.sv */
// Shared types and constants for the bit test and scan unit.
// No dependencies; every module of the unit refers to it by scoped names.
package btsu_pkg;

  localparam logic [2:0] ACT_TEST     = 3'd0;
  localparam logic [2:0] ACT_SET      = 3'd1;
  localparam logic [2:0] ACT_RESET    = 3'd2;
  localparam logic [2:0] ACT_COMPL    = 3'd3;
  localparam logic [2:0] ACT_SCAN_FWD = 3'd4;
  localparam logic [2:0] ACT_SCAN_REV = 3'd5;

  localparam logic [4:0] IDX_MASK16 = 5'h0f;
  localparam logic [4:0] IDX_MASK32 = 5'h1f;

  typedef struct packed {
    logic [2:0]         action;
    logic               wide;
    logic               in_memory;
    logic               from_immediate;
    logic signed [31:0] bit_offset;
    logic [31:0]        base_address;
    logic [31:0]        operand_value;
  } cmd_t;

  typedef struct packed {
    logic [31:0] access_address;
    logic [31:0] result_value;
    logic        write_result;
    logic        carry_flag;
    logic        carry_update;
    logic        zero_flag;
    logic        zero_update;
  } res_t;

  // After decode: operand normalized to the operand size, bit mask ready.
  typedef struct packed {
    logic [2:0]  action;
    logic        is_test;
    logic        is_scan;
    logic [31:0] addr;
    logic [31:0] val;
    logic [31:0] bit_mask;
  } dec_t;

  // After execute: test result done, scan split into per-byte encodings.
  typedef struct packed {
    logic            is_test;
    logic            is_scan;
    logic            modify;
    logic            scan_rev;
    logic [31:0]     addr;
    logic [31:0]     test_res;
    logic            carry;
    logic [3:0]      byte_nz;
    logic [3:0][2:0] byte_lo;
    logic [3:0][2:0] byte_hi;
  } exe_t;

endpackage

/* hw/rtl/btsu_decode.sv */
// First stage: operand size normalization, bit index, mask and address adjustment.
// Depends on btsu_pkg.
module btsu_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  btsu_pkg::cmd_t    cmd,
  output logic              dec_valid,
  input  logic              dec_stall,
  output btsu_pkg::dec_t    dec
);

  btsu_pkg::dec_t dec_next;
  logic [31:0]    off;
  logic [31:0]    delta;
  logic [4:0]     idx;

  assign cmd_stall = dec_valid && dec_stall;

  always_comb begin
    dec_next.action  = cmd.action;
    dec_next.is_test = (cmd.action[2] == 1'b0);
    dec_next.is_scan = (cmd.action == btsu_pkg::ACT_SCAN_FWD) ||
                       (cmd.action == btsu_pkg::ACT_SCAN_REV);
    dec_next.val     = cmd.wide ? cmd.operand_value : {16'h0000, cmd.operand_value[15:0]};
    off = cmd.wide ? cmd.bit_offset : {{16{cmd.bit_offset[15]}}, cmd.bit_offset[15:0]};
    idx = off[4:0] & (cmd.wide ? btsu_pkg::IDX_MASK32 : btsu_pkg::IDX_MASK16);
    dec_next.bit_mask = 32'h1 << idx;
    // floor(off / width) * bytes: arithmetic shift, then scale to bytes
    delta = cmd.wide ? {{3{off[31]}}, off[31:5], 2'b00} : {{3{off[31]}}, off[31:4], 1'b0};
    dec_next.addr = 32'h0;
    if (cmd.in_memory && (dec_next.is_test || dec_next.is_scan)) begin
      dec_next.addr = cmd.base_address;
      if (dec_next.is_test && !cmd.from_immediate) begin
        dec_next.addr = cmd.base_address + delta;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (!cmd_stall) begin
      dec_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      dec <= dec_next;
    end
  end

endmodule

/* hw/rtl/btsu_exec.sv */
// Second stage: set/clear/complement of the tested bit and per-byte scan encoding.
// Depends on btsu_pkg.
module btsu_exec (
  input  logic              clk,
  input  logic              rst,
  input  logic              dec_valid,
  output logic              dec_stall,
  input  btsu_pkg::dec_t    dec,
  output logic              exe_valid,
  input  logic              exe_stall,
  output btsu_pkg::exe_t    exe
);

  btsu_pkg::exe_t exe_next;
  logic [7:0]     byte_val;

  function automatic logic [2:0] lowest_set(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

  function automatic logic [2:0] highest_set(input logic [7:0] v);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

  assign dec_stall = exe_valid && exe_stall;

  always_comb begin
    exe_next.is_test  = dec.is_test;
    exe_next.is_scan  = dec.is_scan;
    exe_next.scan_rev = (dec.action == btsu_pkg::ACT_SCAN_REV);
    exe_next.modify   = dec.is_test && (dec.action != btsu_pkg::ACT_TEST);
    exe_next.addr     = dec.addr;
    exe_next.carry    = |(dec.val & dec.bit_mask);
    unique case (dec.action)
      btsu_pkg::ACT_SET:   exe_next.test_res = dec.val | dec.bit_mask;
      btsu_pkg::ACT_RESET: exe_next.test_res = dec.val & ~dec.bit_mask;
      btsu_pkg::ACT_COMPL: exe_next.test_res = dec.val ^ dec.bit_mask;
      default:             exe_next.test_res = 32'h0;
    endcase
    byte_val = 8'h00;
    for (int b = 0; b < 4; b++) begin
      byte_val            = dec.val[8*b +: 8];
      exe_next.byte_nz[b] = |byte_val;
      exe_next.byte_lo[b] = lowest_set(byte_val);
      exe_next.byte_hi[b] = highest_set(byte_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
    end else if (!dec_stall) begin
      exe_valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && !dec_stall) begin
      exe <= exe_next;
    end
  end

endmodule

/* hw/rtl/btsu_retire.sv */
// Third stage: merge byte scan results, pick the result and flags, hold the output register.
// Depends on btsu_pkg.
module btsu_retire (
  input  logic              clk,
  input  logic              rst,
  input  logic              exe_valid,
  output logic              exe_stall,
  input  btsu_pkg::exe_t    exe,
  output logic              res_valid,
  input  logic              res_stall,
  output btsu_pkg::res_t    res
);

  btsu_pkg::res_t res_next;
  logic [4:0]     fwd_idx;
  logic [4:0]     rev_idx;
  logic           src_zero;

  assign exe_stall = res_valid && res_stall;

  always_comb begin
    fwd_idx = 5'd0;
    rev_idx = 5'd0;
    // lowest nonzero byte wins for forward, highest for reverse
    for (int b = 3; b >= 0; b--) begin
      if (exe.byte_nz[b]) begin
        fwd_idx = {2'(b), exe.byte_lo[b]};
      end
    end
    for (int b = 0; b < 4; b++) begin
      if (exe.byte_nz[b]) begin
        rev_idx = {2'(b), exe.byte_hi[b]};
      end
    end
    src_zero = (exe.byte_nz == 4'h0);

    res_next.access_address = exe.addr;
    res_next.result_value   = 32'h0;
    res_next.write_result   = 1'b0;
    res_next.carry_flag     = 1'b0;
    res_next.carry_update   = 1'b0;
    res_next.zero_flag      = 1'b0;
    res_next.zero_update    = 1'b0;
    if (exe.is_test) begin
      res_next.result_value = exe.test_res;
      res_next.write_result = exe.modify;
      res_next.carry_flag   = exe.carry;
      res_next.carry_update = 1'b1;
    end else if (exe.is_scan) begin
      res_next.zero_update  = 1'b1;
      res_next.zero_flag    = src_zero;
      res_next.write_result = !src_zero;
      if (!src_zero) begin
        res_next.result_value = {27'h0, exe.scan_rev ? rev_idx : fwd_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!exe_stall) begin
      res_valid <= exe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exe_valid && !exe_stall) begin
      res <= res_next;
    end
  end

endmodule

/* hw/rtl/bit_test_and_scan_unit.sv */
// Bit test and bit scan unit: BT, BTS, BTR, BTC, BSF and BSR at 16 or 32 bits.
// Channels: cmd (cmd_valid, cmd_stall, cmd) carries one instruction per transfer;
// res (res_valid, res_stall, res) carries one result per instruction, in order.
// A transfer happens on a rising edge with valid high and stall low.
// A command passes through the decode, execute and retire register stages,
// in that order, before its result is shown on res with res_valid.
// Throughput: one instruction per cycle with no stall on res.
// Each stage holds its item while the stage after it is full and stalled;
// bubbles close up, so cmd_stall rises only when all three stages are full
// and res_stall is high. Nothing is dropped or repeated under stall.
// Reset (rst, synchronous) empties all stages; res_valid is low after it.
// Results carry the adjusted access address, the value to write back with
// its write enable, and carry or zero flags with their update enables.
// Depends on btsu_pkg, btsu_decode, btsu_exec, btsu_retire.
`include "bit_test_and_scan_unit_macros.svh"

module bit_test_and_scan_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  btsu_pkg::cmd_t    cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output btsu_pkg::res_t    res
);

  logic           dec_valid;
  logic           dec_stall;
  btsu_pkg::dec_t dec;
  logic           exe_valid;
  logic           exe_stall;
  btsu_pkg::exe_t exe;

  btsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec)
  );

  btsu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec),
    .exe_valid (exe_valid),
    .exe_stall (exe_stall),
    .exe       (exe)
  );

  btsu_retire u_retire (
    .clk       (clk),
    .rst       (rst),
    .exe_valid (exe_valid),
    .exe_stall (exe_stall),
    .exe       (exe),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `BTSU_NEVER(a_one_update_kind, res_valid && res.carry_update && res.zero_update, "both flag updates set")
  `BTSU_ASSERT(a_zero_no_write, (res_valid && res.zero_flag) |-> (!res.write_result && res.result_value == 32'h0), "zero scan source wrote a result")
  `BTSU_ASSERT(a_scan_index_range, (res_valid && res.zero_update) |-> (res.result_value[31:5] == 27'h0), "scan index out of range")
  `BTSU_ASSERT(a_stall_only_full, cmd_stall |-> (dec_valid && exe_valid && res_valid && res_stall), "input stalled with room in the pipeline")
  `BTSU_ASSERT(a_fill_one_cycle, (cmd_valid && !cmd_stall) |=> dec_valid, "accepted command did not reach decode stage")

endmodule
